// File: sv/dcssw_pkg.sv
// Shared types, constants and helper functions for the dual counter seven-segment writer.
// Used by dcssw_front, dcssw_queue, dcssw_back and the top level; depends on nothing.
`default_nettype none

package dcssw_pkg;

   // Input and display geometry.
   localparam int ValueW         = 14;
   localparam int NumGroups      = 2;
   localparam int DigitsPerGroup = 4;
   localparam int NumDigits      = NumGroups * DigitsPerGroup;
   localparam int PosW           = $clog2(NumDigits);

   localparam logic [ValueW-1:0] MaxValue = 14'd9999;

   // Operation codes carried by the input item.
   typedef enum logic {
      OP_INIT = 1'b0,
      OP_SHOW = 1'b1
   } op_type;

   // Controller command bytes.
   localparam logic [7:0] CmdDisplayOn  = 8'h8F;
   localparam logic [7:0] CmdAutoInc    = 8'h40;
   localparam logic [7:0] CmdFixedAddr  = 8'h44;
   localparam logic [7:0] AddrBase      = 8'hC0;

   // The initialise burst: two commands, the address byte, then sixteen zero bytes.
   localparam int               InitBytes   = 19;
   localparam int               InitIdxW    = $clog2(InitBytes);
   localparam logic [InitIdxW-1:0] InitIdxOn   = InitIdxW'(0);
   localparam logic [InitIdxW-1:0] InitIdxAuto = InitIdxW'(1);
   localparam logic [InitIdxW-1:0] InitIdxAddr = InitIdxW'(2);
   localparam logic [InitIdxW-1:0] InitIdxLast = InitIdxW'(InitBytes - 1);

   // Division by ten through a reciprocal: exact for every 14-bit operand whose quotient fits QuotW bits.
   localparam logic [15:0] Recip10      = 16'd52429;
   localparam int          Recip10Shift = 19;
   localparam int          QuotW        = 10;

   localparam int QueueDepthDefault = 2;

   // One classified item as it waits between the front and the back.
   typedef struct packed {
      op_type                       op;
      logic [NumDigits-1:0][7:0]    seg;
   } entry_type;

   function automatic logic [QuotW-1:0] div10(input logic [ValueW-1:0] x);
      logic [29:0] prod;
      prod = 30'(x) * 30'(Recip10);
      return prod[Recip10Shift +: QuotW];
   endfunction

   function automatic logic [ValueW-1:0] times10(input logic [ValueW-1:0] x);
      return (x << 3) + (x << 1);
   endfunction

   // Segment pattern, bit 0 = a up to bit 6 = g.
   function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
      logic [7:0] pat;
      case (digit)
         4'd0:    pat = 8'b0011_1111;
         4'd1:    pat = 8'b0000_0110;
         4'd2:    pat = 8'b0101_1011;
         4'd3:    pat = 8'b0100_1111;
         4'd4:    pat = 8'b0110_0110;
         4'd5:    pat = 8'b0110_1101;
         4'd6:    pat = 8'b0111_1101;
         4'd7:    pat = 8'b0000_0111;
         4'd8:    pat = 8'b0111_1111;
         4'd9:    pat = 8'b0110_1111;
         default: pat = 8'b0000_0000;
      endcase
      return pat;
   endfunction

endpackage

`default_nettype wire

// File: sv/dcssw_front.sv
// Front end: accepts input items, saturates the values and turns them into segment patterns.
// Three-stage pipeline of divide-by-ten steps; depends on dcssw_pkg.
`default_nettype none

module dcssw_front (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire                          req_operation,
   input  wire  [dcssw_pkg::ValueW-1:0] req_left_value,
   input  wire  [dcssw_pkg::ValueW-1:0] req_right_value,
   output logic                         push_valid,
   output dcssw_pkg::entry_type         push_entry,
   input  wire                          push_ready
);
   import dcssw_pkg::*;

   logic advance;

   logic   st1_valid_ff, st2_valid_ff, st3_valid_ff;
   op_type st1_op_ff, st2_op_ff, st3_op_ff;

   logic [ValueW-1:0] sat_in    [NumGroups];
   logic [QuotW-1:0]  q1_in     [NumGroups];
   logic [3:0]        units_in  [NumGroups];
   logic [6:0]        q2_in     [NumGroups];
   logic [3:0]        tens_in   [NumGroups];
   logic [3:0]        q3_in     [NumGroups];

   logic [ValueW-1:0] st1_sat_ff   [NumGroups];
   logic [QuotW-1:0]  st1_q1_ff    [NumGroups];
   logic [3:0]        st2_units_ff [NumGroups];
   logic [QuotW-1:0]  st2_q1_ff    [NumGroups];
   logic [6:0]        st2_q2_ff    [NumGroups];
   logic [3:0]        st3_units_ff [NumGroups];
   logic [3:0]        st3_tens_ff  [NumGroups];
   logic [6:0]        st3_q2_ff    [NumGroups];
   logic [3:0]        st3_q3_ff    [NumGroups];

   // The whole pipeline holds when its last stage cannot hand over.
   assign advance    = ~(st3_valid_ff & ~push_ready);
   assign req_ready  = advance;
   assign push_valid = st3_valid_ff;

   always_comb begin
      logic [ValueW-1:0] raw [NumGroups];
      raw[0] = req_left_value;
      raw[1] = req_right_value;
      for (int g = 0; g < NumGroups; g++) begin
         sat_in[g]   = (raw[g] > MaxValue) ? MaxValue : raw[g];
         q1_in[g]    = div10(sat_in[g]);
         units_in[g] = 4'(st1_sat_ff[g] - times10(ValueW'(st1_q1_ff[g])));
         q2_in[g]    = 7'(div10(ValueW'(st1_q1_ff[g])));
         tens_in[g]  = 4'(ValueW'(st2_q1_ff[g]) - times10(ValueW'(st2_q2_ff[g])));
         q3_in[g]    = 4'(div10(ValueW'(st2_q2_ff[g])));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_valid_ff <= 1'b0;
         st2_valid_ff <= 1'b0;
         st3_valid_ff <= 1'b0;
      end else if (advance) begin
         st1_valid_ff <= req_valid;
         st2_valid_ff <= st1_valid_ff;
         st3_valid_ff <= st2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st1_op_ff <= op_type'(req_operation);
         st2_op_ff <= st1_op_ff;
         st3_op_ff <= st2_op_ff;
         for (int g = 0; g < NumGroups; g++) begin
            st1_sat_ff[g]   <= sat_in[g];
            st1_q1_ff[g]    <= q1_in[g];
            st2_units_ff[g] <= units_in[g];
            st2_q1_ff[g]    <= st1_q1_ff[g];
            st2_q2_ff[g]    <= q2_in[g];
            st3_units_ff[g] <= st2_units_ff[g];
            st3_tens_ff[g]  <= tens_in[g];
            st3_q2_ff[g]    <= st2_q2_ff[g];
            st3_q3_ff[g]    <= q3_in[g];
         end
      end
   end

   // Last remainder, leading-zero blanking and segment lookup.
   always_comb begin
      logic [3:0] thou, hund;
      push_entry.op = st3_op_ff;
      for (int g = 0; g < NumGroups; g++) begin
         thou = st3_q3_ff[g];
         hund = 4'(ValueW'(st3_q2_ff[g]) - times10(ValueW'(st3_q3_ff[g])));
         push_entry.seg[g*DigitsPerGroup + 0] = (thou == 4'd0) ? 8'h00 : seg_pattern(thou);
         push_entry.seg[g*DigitsPerGroup + 1] =
            (thou == 4'd0 && hund == 4'd0) ? 8'h00 : seg_pattern(hund);
         push_entry.seg[g*DigitsPerGroup + 2] =
            (thou == 4'd0 && hund == 4'd0 && st3_tens_ff[g] == 4'd0) ?
            8'h00 : seg_pattern(st3_tens_ff[g]);
         push_entry.seg[g*DigitsPerGroup + 3] = seg_pattern(st3_units_ff[g]);
      end
   end

   a_hold_when_blocked : assert property (@(posedge clock) disable iff (reset)
      (st3_valid_ff && !push_ready) |=> (st3_valid_ff && $stable(st3_op_ff)))
      else $error("front output stage changed while blocked");

   a_no_accept_when_blocked : assert property (@(posedge clock) disable iff (reset)
      (st3_valid_ff && !push_ready) |-> !req_ready)
      else $error("front accepted an item while its last stage was blocked");

endmodule

`default_nettype wire

// File: sv/dcssw_queue.sv
// Short queue of classified items between the front and the back.
// Register-based circular buffer; depends on dcssw_pkg.
`default_nettype none

module dcssw_queue #(
   parameter int Depth = dcssw_pkg::QueueDepthDefault
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push_valid,
   output logic                  push_ready,
   input  dcssw_pkg::entry_type  push_entry,
   output logic                  pop_valid,
   input  wire                   pop_ready,
   output dcssw_pkg::entry_type  pop_entry
);
   import dcssw_pkg::*;

   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);

   entry_type         slot_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]   count_ff;
   logic              push, pop;

   assign push_ready = (count_ff != CntW'(Depth));
   assign pop_valid  = (count_ff != CntW'(0));
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;
   assign pop_entry  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("queue fill count beyond depth");

   a_ptr_gap : assert property (@(posedge clock) disable iff (reset)
      (count_ff == CntW'(0) || count_ff == CntW'(Depth)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with the fill count");

endmodule

`default_nettype wire

// File: sv/dcssw_back.sv
// Back end: walks through the byte sequence of the item at the queue head, one byte a cycle
// while the result side accepts. Drives the registered result channel; depends on dcssw_pkg.
`default_nettype none

module dcssw_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   pop_valid,
   output logic                  pop_ready,
   input  dcssw_pkg::entry_type  pop_entry,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output logic [7:0]            rsp_byte_out,
   output logic                  rsp_frame_start,
   output logic                  rsp_frame_end,
   output logic                  rsp_last
);
   import dcssw_pkg::*;

   typedef enum logic [1:0] {
      PH_CMD,
      PH_ADDR,
      PH_SEG
   } phase_type;

   phase_type             phase_ff;
   logic [PosW-1:0]       pos_ff;
   logic [InitIdxW-1:0]   idx_ff;

   logic       rsp_valid_ff, rsp_frame_start_ff, rsp_frame_end_ff, rsp_last_ff;
   logic [7:0] rsp_byte_out_ff;

   logic       emit;
   logic [7:0] byte_in;
   logic       start_in, end_in, last_in;

   assign emit      = pop_valid & (~rsp_valid_ff | rsp_ready);
   assign pop_ready = emit & last_in;

   always_comb begin
      byte_in  = 8'h00;
      start_in = 1'b0;
      end_in   = 1'b0;
      last_in  = 1'b0;
      if (pop_entry.op == OP_INIT) begin
         case (idx_ff)
            InitIdxOn: begin
               byte_in  = CmdDisplayOn;
               start_in = 1'b1;
               end_in   = 1'b1;
            end
            InitIdxAuto: begin
               byte_in  = CmdAutoInc;
               start_in = 1'b1;
               end_in   = 1'b1;
            end
            InitIdxAddr: begin
               byte_in  = AddrBase;
               start_in = 1'b1;
            end
            default: begin
               end_in  = (idx_ff == InitIdxLast);
               last_in = (idx_ff == InitIdxLast);
            end
         endcase
      end else begin
         case (phase_ff)
            PH_CMD: begin
               byte_in  = CmdFixedAddr;
               start_in = 1'b1;
               end_in   = 1'b1;
            end
            PH_ADDR: begin
               byte_in  = AddrBase | 8'({pos_ff, 1'b0});
               start_in = 1'b1;
            end
            PH_SEG: begin
               byte_in = pop_entry.seg[pos_ff];
               end_in  = 1'b1;
               last_in = (pos_ff == PosW'(NumDigits - 1));
            end
            default: begin
               byte_in = 8'h00;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_CMD;
         pos_ff       <= '0;
         idx_ff       <= '0;
      end else begin
         if (emit) begin
            rsp_valid_ff       <= 1'b1;
            rsp_byte_out_ff    <= byte_in;
            rsp_frame_start_ff <= start_in;
            rsp_frame_end_ff   <= end_in;
            rsp_last_ff        <= last_in;
            if (last_in) begin
               phase_ff <= PH_CMD;
               pos_ff   <= '0;
               idx_ff   <= '0;
            end else if (pop_entry.op == OP_INIT) begin
               idx_ff <= idx_ff + 1'b1;
            end else begin
               case (phase_ff)
                  PH_CMD:  phase_ff <= PH_ADDR;
                  PH_ADDR: phase_ff <= PH_SEG;
                  default: begin
                     phase_ff <= PH_CMD;
                     pos_ff   <= pos_ff + 1'b1;
                  end
               endcase
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_byte_out    = rsp_byte_out_ff;
   assign rsp_frame_start = rsp_frame_start_ff;
   assign rsp_frame_end   = rsp_frame_end_ff;
   assign rsp_last        = rsp_last_ff;

   a_last_closes_frame : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> rsp_frame_end_ff)
      else $error("final byte of an item does not close its frame");

   a_idx_range : assert property (@(posedge clock) disable iff (reset)
      idx_ff <= InitIdxLast)
      else $error("initialise byte index out of range");

   a_counters_idle : assert property (@(posedge clock) disable iff (reset)
      $past(pop_ready) |-> (idx_ff == '0 && pos_ff == '0 && phase_ff == PH_CMD))
      else $error("sequencer not rewound after an item completed");

endmodule

`default_nettype wire

// File: sv/dual_counter_seven_segment_writer.sv
// Top level of the dual counter seven-segment writer.
// Instantiates dcssw_front, dcssw_queue and dcssw_back; depends on dcssw_pkg.
`default_nettype none

// Each input item becomes a burst of bytes for a strobed serial display controller, every
// byte to be shifted out least significant bit first. An initialise item (operation 0) gives
// nineteen bytes: the display-on command, the auto-increment command, then one frame made of
// the base address and sixteen zero bytes, which clears all digits. A display item
// (operation 1) gives twenty-four bytes: for each of the eight digits a fixed-address
// command and a two-byte frame of digit address and segment pattern. Both values saturate at
// 9999, leading zeros of each four-digit group are blanked and the units digit is always
// shown. frame_start marks a byte before which the strobe goes low, frame_end one after which
// it goes high, and last marks the final byte of the item. The front end takes an item in any
// cycle in which its pipeline is not blocked and turns the values into segment patterns in
// registered steps; classified items then wait in a short queue. The back end sends exactly
// one byte per cycle while the result side accepts, and takes a new item from the queue
// only once the last byte of the current item has been sent. A result register sits on the
// output, so the next byte is taken into it as the current one is transferred. An item
// passes the front pipeline registers, a queue slot and that register on its way out.
module dual_counter_seven_segment_writer #(
   parameter int QueueDepth = dcssw_pkg::QueueDepthDefault
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire                          req_operation,
   input  wire  [dcssw_pkg::ValueW-1:0] req_left_value,
   input  wire  [dcssw_pkg::ValueW-1:0] req_right_value,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [7:0]                   rsp_byte_out,
   output logic                         rsp_frame_start,
   output logic                         rsp_frame_end,
   output logic                         rsp_last
);
   import dcssw_pkg::*;

   // Classified items leaving the front end.
   logic      push_valid, push_ready;
   entry_type push_entry;

   // Item at the head of the queue, held until its last byte is sent.
   logic      pop_valid, pop_ready;
   entry_type pop_entry;

   dcssw_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_left_value  (req_left_value),
      .req_right_value (req_right_value),
      .push_valid      (push_valid),
      .push_entry      (push_entry),
      .push_ready      (push_ready)
   );

   dcssw_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   dcssw_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_entry       (pop_entry),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_byte_out    (rsp_byte_out),
      .rsp_frame_start (rsp_frame_start),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire
